// ===== rtl/sstf_pkg.sv =====
package sstf_pkg;

  localparam int MAX_REQUESTS = 16;
  localparam int TRACK_COUNT  = 256;

  localparam int TRACK_W = 8;
  localparam int DIST_W  = 8;
  localparam int TOTAL_W = 12;
  localparam int IDX_W   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W   = $clog2(MAX_REQUESTS + 1);

  localparam logic [DIST_W-1:0]  BEST_INIT = DIST_W'(TRACK_COUNT - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(MAX_REQUESTS);

  typedef struct packed {
    logic [TRACK_W-1:0] request_track;
    logic               last;
  } req_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic [DIST_W-1:0]  move_distance;
    logic [TOTAL_W-1:0] total_seek;
    logic               last_result;
  } res_t;

  typedef struct packed {
    logic load;
    logic begin_batch;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic batch_done;
  } ctrl_stat_t;

endpackage

// ===== rtl/sstf_ctrl.sv =====
module sstf_ctrl
  import sstf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       last,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    busy            = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (last) begin
            cmd.begin_batch = 1'b1;
            state_next      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.batch_done) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sstf_datapath.sv =====
module sstf_datapath
  import sstf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [TRACK_W-1:0] cfg_data,
  input  req_t               request,
  input  ctrl_cmd_t          cmd,
  output ctrl_stat_t         stat,
  output res_t               result,
  output logic               result_valid
);

  logic [TRACK_W-1:0]      start_track;
  logic [TRACK_W-1:0]      store [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] served;
  logic [CNT_W-1:0]        loaded_count;
  logic [IDX_W-1:0]        scan_idx;
  logic [IDX_W-1:0]        serve_idx;
  logic [IDX_W-1:0]        pick;
  logic [TRACK_W-1:0]      pick_track;
  logic [DIST_W-1:0]       best;
  logic [TRACK_W-1:0]      head;
  logic [TOTAL_W-1:0]      total;

  logic [TRACK_W-1:0]      cand;
  logic [DIST_W-1:0]       head_gap;
  logic                    better;
  logic [TOTAL_W:0]        sum;
  logic [TOTAL_W-1:0]      total_next;

  assign cand     = store[scan_idx];
  assign head_gap = (head >= cand) ? DIST_W'(head - cand) : DIST_W'(cand - head);
  assign better   = !served[scan_idx] && (head_gap <= best);

  assign sum        = {1'b0, total} + (TOTAL_W + 1)'(best);
  assign total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  assign stat.scan_done  = ((CNT_W'(scan_idx) + CNT_W'(1)) == loaded_count);
  assign stat.batch_done = ((CNT_W'(serve_idx) + CNT_W'(1)) == loaded_count);

  always_ff @(posedge clk) begin
    if (cmd.load && (loaded_count < CNT_FULL)) begin
      store[loaded_count[IDX_W-1:0]] <= request.request_track;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_track  <= '0;
      served       <= '0;
      loaded_count <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cfg_we) begin
        start_track <= cfg_data;
      end
      if (cmd.load && (loaded_count < CNT_FULL)) begin
        loaded_count <= loaded_count + CNT_W'(1);
      end
      if (cmd.begin_batch) begin
        served <= '0;
      end else if (cmd.emit) begin
        served[pick] <= 1'b1;
        if (stat.batch_done) begin
          served       <= '0;
          loaded_count <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_batch) begin
      head      <= start_track;
      total     <= '0;
      scan_idx  <= '0;
      serve_idx <= '0;
      best      <= BEST_INIT;
      pick      <= '0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (better) begin
        best       <= head_gap;
        pick       <= scan_idx;
        pick_track <= cand;
      end
    end else if (cmd.emit) begin
      head                 <= pick_track;
      total                <= total_next;
      serve_idx            <= serve_idx + IDX_W'(1);
      scan_idx             <= '0;
      best                 <= BEST_INIT;
      result.served_track  <= pick_track;
      result.move_distance <= best;
      result.total_seek    <= total_next;
      result.last_result   <= stat.batch_done;
    end
  end

endmodule

// ===== rtl/sstf_disk_scheduler.sv =====
// Load: one request transfer per cycle while busy is low; no result.
// Batch of N requests: after the transfer with last set, each result takes
// a scan of the N stored requests (one compared per cycle) and then a select
// state that registers the result; the scan restarts after each result.
// Busy stays high until the final result is selected. Synchronous reset
// clears the controller, the loaded count, served flags and start_track.
module sstf_disk_scheduler
  import sstf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               request,
  input  logic               cfg_we,
  input  logic [TRACK_W-1:0] cfg_data,
  output res_t               result,
  output logic               result_valid
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  sstf_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .last (request.last),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  sstf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .request     (request),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result),
    .result_valid(result_valid)
  );

endmodule

// ===== rtl/sstf_checker.sv =====
module sstf_checker
  import sstf_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t request,
  input res_t result,
  input logic result_valid
);

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !request.last) |=> !busy)
    else $error("busy rose after a load transfer");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.last) |=> busy)
    else $error("busy low after last transfer");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_result) |-> busy)
    else $error("idle before final result");

  a_final_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_result) |-> !busy)
    else $error("busy after final result");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results in adjacent cycles");

endmodule

bind sstf_disk_scheduler sstf_checker u_sstf_checker (.*);

// ===== dv/sstf_disk_scheduler_test.sv =====
`timescale 1ns / 100ps

module sstf_disk_scheduler_test;
  import sstf_pkg::*;

  localparam int ITEM_TARGET    = 280;
  localparam int SETTLE_CYCLES  = MAX_REQUESTS + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_ROWS       = 32;
  localparam int PRINT_LIMIT    = 100;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;
  typedef enum int {SPREAD_WIDE, SPREAD_NEAR, SPREAD_EDGE, SPREAD_FEW} spread_t;

  typedef struct {
    row_kind_t          kind;
    logic [TRACK_W-1:0] value;
    logic               last;
    bit                 typed;
    res_t               want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  req_t               request;
  logic               cfg_we;
  logic [TRACK_W-1:0] cfg_data;
  res_t               result;
  logic               result_valid;

  logic [TRACK_W-1:0] home_track;
  logic [TRACK_W-1:0] pending_tracks [MAX_REQUESTS];
  int                 pending_count;
  logic [TRACK_W-1:0] head_track;
  logic [TOTAL_W-1:0] seek_sum;
  res_t               service_order [$];

  stim_row_t directed_rows [MAX_ROWS];
  int        row_count;
  int        errors;
  int        items_sent;
  int        burst_left;
  int        idle_cycles = 0;

  sstf_disk_scheduler dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (result_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string what);
    errors++;
    if (errors <= PRINT_LIMIT) $display("error at %0t: %s", $time, what);
  endtask

  function automatic int unsigned seek_gap(logic [TRACK_W-1:0] a, logic [TRACK_W-1:0] b);
    return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  task automatic schedule_batch(bit typed, res_t want);
    logic [MAX_REQUESTS-1:0] taken;
    int unsigned             best;
    int unsigned             gap;
    int                      pick;
    bit                      found;
    res_t                    r;
    taken = '0;
    head_track = home_track;
    seek_sum = '0;
    for (int k = 0; k < pending_count; k++) begin
      best = TRACK_COUNT - 1;
      pick = 0;
      found = 1'b0;
      for (int j = 0; j < pending_count; j++) begin
        if (!taken[j]) begin
          gap = seek_gap(head_track, pending_tracks[j]);
          if (gap <= best) begin
            best = gap;
            pick = j;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        for (int j = pending_count - 1; j >= 0; j--) begin
          if (!taken[j]) pick = j;
        end
        best = seek_gap(head_track, pending_tracks[pick]);
      end
      taken[pick] = 1'b1;
      head_track = pending_tracks[pick];
      if (seek_sum + best > TOTAL_MAX) seek_sum = TOTAL_MAX;
      else seek_sum = TOTAL_W'(seek_sum + best);
      r.served_track  = head_track;
      r.move_distance = best[DIST_W-1:0];
      r.total_seek    = seek_sum;
      r.last_result   = (k == pending_count - 1);
      service_order.push_back(typed ? want : r);
    end
    pending_count = 0;
  endtask

  task automatic take_request(req_t item, bit typed, res_t want);
    if (pending_count < MAX_REQUESTS) begin
      pending_tracks[pending_count] = item.request_track;
      pending_count++;
    end
    if (item.last) schedule_batch(typed, want);
  endtask

  task automatic send_request(req_t item, bit typed, res_t want);
    @(negedge clk);
    start = 1'b1;
    request = item;
    do @(posedge clk); while (busy);
    take_request(item, typed, want);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
    end
  endtask

  task automatic write_home(logic [TRACK_W-1:0] value);
    @(negedge clk);
    start = 1'b0;
    while (service_order.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = value;
    @(posedge clk);
    home_track = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_row(row_kind_t kind, logic [TRACK_W-1:0] value, logic last, bit typed,
                         res_t want);
    directed_rows[row_count].kind  = kind;
    directed_rows[row_count].value = value;
    directed_rows[row_count].last  = last;
    directed_rows[row_count].typed = typed;
    directed_rows[row_count].want  = want;
    row_count++;
  endtask

  task automatic build_directed();
    row_count = 0;
    add_row(ROW_REQ, 8'd0,   1'b1, 1'b1, {8'd0,   8'd0,   12'd0,   1'b1});
    add_row(ROW_REQ, 8'd255, 1'b1, 1'b1, {8'd255, 8'd255, 12'd255, 1'b1});
    add_row(ROW_CFG, 8'd255, 1'b0, 1'b0, '0);
    add_row(ROW_REQ, 8'd0,   1'b1, 1'b1, {8'd0,   8'd255, 12'd255, 1'b1});
    add_row(ROW_REQ, 8'd255, 1'b1, 1'b1, {8'd255, 8'd0,   12'd0,   1'b1});
    // equal distance from the head: later transfer wins
    add_row(ROW_CFG, 8'd128, 1'b0, 1'b0, '0);
    add_row(ROW_REQ, 8'd100, 1'b0, 1'b0, '0);
    add_row(ROW_REQ, 8'd156, 1'b1, 1'b0, '0);
    // fill the store, then drop a request right at the head
    add_row(ROW_CFG, 8'd0,   1'b0, 1'b0, '0);
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      add_row(ROW_REQ, TRACK_W'(i * 16 + 15), 1'b0, 1'b0, '0);
    end
    add_row(ROW_REQ, 8'd0,   1'b1, 1'b0, '0);
  endtask

  function automatic logic [TRACK_W-1:0] pick_track(spread_t spread, logic [TRACK_W-1:0] base);
    case (spread)
      SPREAD_WIDE: return TRACK_W'($urandom_range(0, 255));
      SPREAD_NEAR: return TRACK_W'(int'(base) + $urandom_range(0, 6) - 3);
      SPREAD_EDGE: return $urandom_range(0, 1) ? {TRACK_W{1'b1}} : {TRACK_W{1'b0}};
      default:     return base ^ TRACK_W'($urandom_range(0, 3) << 6);
    endcase
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst && result_valid) begin
      if (service_order.size() == 0) begin
        report($sformatf("result track %0d with nothing pending", result.served_track));
      end else begin
        want = service_order.pop_front();
        if (result.served_track !== want.served_track)
          report($sformatf("served_track %0d, want %0d", result.served_track,
                           want.served_track));
        if (result.move_distance !== want.move_distance)
          report($sformatf("move_distance %0d, want %0d", result.move_distance,
                           want.move_distance));
        if (result.total_seek !== want.total_seek)
          report($sformatf("total_seek %0d, want %0d", result.total_seek, want.total_seek));
        if (result.last_result !== want.last_result)
          report($sformatf("last_result %0b, want %0b", result.last_result,
                           want.last_result));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sstf_disk_scheduler: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    req_t               item;
    res_t               none;
    int                 batch_size;
    int                 batch_no;
    int                 roll;
    spread_t            spread;
    logic [TRACK_W-1:0] base;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    burst_left = 0;
    pending_count = 0;
    home_track = '0;
    head_track = '0;
    seek_sum = '0;
    none = '0;
    build_directed();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < row_count; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_home(directed_rows[i].value);
      end else begin
        item.request_track = directed_rows[i].value;
        item.last = directed_rows[i].last;
        send_request(item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    batch_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (batch_no % 3 == 0) begin
        case ($urandom_range(0, 3))
          0: write_home({TRACK_W{1'b0}});
          1: write_home({TRACK_W{1'b1}});
          default: write_home(TRACK_W'($urandom_range(0, 255)));
        endcase
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) batch_size = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
      else if (roll <= 2) batch_size = $urandom_range(9, MAX_REQUESTS);
      else batch_size = $urandom_range(1, 8);
      spread = spread_t'($urandom_range(0, 3));
      base = TRACK_W'($urandom_range(0, 255));
      for (int n = 1; n <= batch_size; n++) begin
        item.request_track = pick_track(spread, base);
        item.last = (n == batch_size);
        send_request(item, 1'b0, none);
      end
      batch_no++;
    end

    @(negedge clk);
    start = 1'b0;
    while (service_order.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (service_order.size() != 0)
      report($sformatf("%0d results never arrived", service_order.size()));
    if (errors == 0) $display("sstf_disk_scheduler: match");
    else $display("sstf_disk_scheduler: mismatch");
    $finish;
  end

endmodule

// ===== sstf_disk_scheduler.f =====
rtl/sstf_pkg.sv
rtl/sstf_ctrl.sv
rtl/sstf_datapath.sv
rtl/sstf_disk_scheduler.sv
rtl/sstf_checker.sv
dv/sstf_disk_scheduler_test.sv
